@@ hdl/jpcu_pkg.sv @@
// ----------------------------------------------------------------------------
// jpcu_pkg
// Types, register codes and the per-cell operation of the junction update row.
// ----------------------------------------------------------------------------
package jpcu_pkg;

	// register file
	localparam int NUM_REGS = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_Z = 3'd5;

	localparam logic [31:0] GAIN_RESET = 32'd0;
	localparam logic [31:0] AREA_RESET = 32'd65536;

	// edge direction codes
	localparam logic [1:0] DIR_X = 2'd0;
	localparam logic [1:0] DIR_Y = 2'd1;
	localparam logic [1:0] DIR_Z = 2'd2;
	localparam logic [1:0] DIR_NONE = 2'd3;

	// cell operation codes, one per position in the row
	localparam int NUM_CELLS = 12;
	localparam logic [3:0] STG_STEP = 4'd0;   // field * gain
	localparam logic [3:0] STG_PHASE = 4'd1;  // phase advance, wraps
	localparam logic [3:0] STG_FOLD = 4'd2;   // fold to quarter turn, Q16 angle
	localparam logic [3:0] STG_SQ = 4'd3;     // u^2
	localparam logic [3:0] STG_INNER = 4'd4;  // 4640 * t2
	localparam logic [3:0] STG_MID = 4'd5;    // t2 * (42048 - inner)
	localparam logic [3:0] STG_POLY = 4'd6;   // u * (102944 - mid)
	localparam logic [3:0] STG_SINE = 4'd7;   // Q0.15 magnitude, clamped
	localparam logic [3:0] STG_M1 = 4'd8;     // crit_current * sine
	localparam logic [3:0] STG_M2 = 4'd9;     // times inverse area
	localparam logic [3:0] STG_SAT = 4'd10;   // sign and saturate
	localparam logic [3:0] STG_CUR = 4'd11;   // total current, pass-through

	typedef struct packed {
		logic [2:0][31:0] gain;
		logic [2:0][31:0] inv_area;
	} cfg_t;

	// word handed from cell to cell
	typedef struct packed {
		logic [1:0]  dir;
		logic        act;
		logic [31:0] ic;
		logic [31:0] fld;
		logic [31:0] ph;
		logic [31:0] js_old;
		logic [31:0] cur_old;
		logic [31:0] dph;
		logic        neg;
		logic [16:0] u;
		logic [16:0] t2;
		logic [12:0] inner;
		logic [15:0] mid;
		logic [16:0] y;
		logic [14:0] s;
		logic [32:0] m1;
		logic [49:0] m2;
		logic [31:0] js_new;
		logic [31:0] cur_new;
	} word_t;

	function automatic word_t cell_op(input logic [3:0] stage, input cfg_t cfg,
			input word_t w);
		word_t r;
		logic signed [31:0] gain;
		logic signed [63:0] prod;
		logic [31:0] h;
		logic [31:0] t;
		logic [31:0] tr;
		logic [33:0] sq;
		logic [29:0] p_in;
		logic [32:0] p_mid;
		logic [16:0] k_poly;
		logic [33:0] p_poly;
		logic [17:0] ys;
		logic [46:0] p_m1;
		logic [47:0] p_m1r;
		logic [31:0] ia;
		logic [64:0] p_m2;
		logic [65:0] p_m2r;
		logic [49:0] mag;
		logic signed [33:0] sum;
		r = w;
		case (stage)
			STG_STEP: begin
				r.act = (w.ic != 32'd0) && (w.dir != DIR_NONE);
				gain = (w.dir == DIR_NONE) ? 32'sd0 : $signed(cfg.gain[w.dir]);
				prod = $signed(w.fld) * gain;
				r.dph = prod[63:32];
			end
			STG_PHASE: begin
				if (w.act) begin
					r.ph = w.ph + w.dph;
				end
			end
			STG_FOLD: begin
				r.neg = w.ph[31];
				h = {1'b0, w.ph[30:0]};
				t = (h < 32'h4000_0000) ? h : (32'h8000_0000 - h);
				tr = t + 32'h0000_2000;
				r.u = tr[30:14];
			end
			STG_SQ: begin
				sq = 34'(w.u) * 34'(w.u);
				r.t2 = sq[32:16];
			end
			STG_INNER: begin
				p_in = 30'(w.t2) * 30'd4640;
				r.inner = p_in[28:16];
			end
			STG_MID: begin
				p_mid = 33'(w.t2) * 33'(16'd42048 - 16'(w.inner));
				r.mid = p_mid[31:16];
			end
			STG_POLY: begin
				k_poly = 17'd102944 - 17'(w.mid);
				p_poly = 34'(w.u) * 34'(k_poly);
				r.y = p_poly[32:16];
			end
			STG_SINE: begin
				ys = (18'(w.y) + 18'd1) >> 1;
				r.s = (ys > 18'd32767) ? 15'h7FFF : ys[14:0];
			end
			STG_M1: begin
				p_m1 = 47'(w.ic) * 47'(w.s);
				p_m1r = 48'(p_m1) + 48'h4000;
				r.m1 = p_m1r[47:15];
			end
			STG_M2: begin
				ia = (w.dir == DIR_NONE) ? 32'd0 : cfg.inv_area[w.dir];
				p_m2 = 65'(w.m1) * 65'(ia);
				p_m2r = 66'(p_m2) + 66'h8000;
				r.m2 = p_m2r[65:16];
			end
			STG_SAT: begin
				// negative side reaches one step further than positive
				if (w.neg) begin
					mag = (w.m2 > 50'h8000_0000) ? 50'h8000_0000 : w.m2;
					r.js_new = 32'(-mag);
				end else begin
					mag = (w.m2 > 50'h7FFF_FFFF) ? 50'h7FFF_FFFF : w.m2;
					r.js_new = mag[31:0];
				end
			end
			STG_CUR: begin
				sum = 34'($signed(w.cur_old)) + 34'($signed(w.js_new))
					- 34'($signed(w.js_old));
				if (sum > 34'sh0_7FFF_FFFF) begin
					r.cur_new = 32'h7FFF_FFFF;
				end else if (sum < -34'sh0_8000_0000) begin
					r.cur_new = 32'h8000_0000;
				end else begin
					r.cur_new = sum[31:0];
				end
				// no junction: everything passes through
				if (!w.act) begin
					r.js_new = w.js_old;
					r.cur_new = w.cur_old;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

endpackage

@@ hdl/jpcu_regs.sv @@
// ----------------------------------------------------------------------------
// jpcu_regs
// Per-direction phase gains and inverse areas, written through a plain port.
// ----------------------------------------------------------------------------
module jpcu_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [jpcu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jpcu_pkg::CFG_DATA_W-1:0] cfg_data,
	output jpcu_pkg::cfg_t                  cfg
);

	jpcu_pkg::cfg_t cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain <= {3{jpcu_pkg::GAIN_RESET}};
			cfg_q.inv_area <= {3{jpcu_pkg::AREA_RESET}};
		end else if (cfg_we) begin
			case (cfg_index)
				jpcu_pkg::REG_GAIN_X: cfg_q.gain[0] <= cfg_data;
				jpcu_pkg::REG_GAIN_Y: cfg_q.gain[1] <= cfg_data;
				jpcu_pkg::REG_GAIN_Z: cfg_q.gain[2] <= cfg_data;
				jpcu_pkg::REG_AREA_X: cfg_q.inv_area[0] <= cfg_data;
				jpcu_pkg::REG_AREA_Y: cfg_q.inv_area[1] <= cfg_data;
				jpcu_pkg::REG_AREA_Z: cfg_q.inv_area[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/jpcu_cell.sv @@
// ----------------------------------------------------------------------------
// jpcu_cell
// One slot of the update row: applies its step and holds the word for its
// right-hand neighbor, with elastic valid/ready toward both sides.
// ----------------------------------------------------------------------------
module jpcu_cell #(
	parameter logic [3:0] STAGE = jpcu_pkg::STG_STEP
) (
	input  logic            clk,
	input  logic            arst_n,
	input  jpcu_pkg::cfg_t  cfg,
	input  logic            up_valid,
	output logic            up_ready,
	input  jpcu_pkg::word_t up_word,
	output logic            dn_valid,
	input  logic            dn_ready,
	output jpcu_pkg::word_t dn_word
);

	logic            valid_q;
	jpcu_pkg::word_t word_q;

	// slot takes a word when empty or when its neighbor takes the current one
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_q <= jpcu_pkg::cell_op(STAGE, cfg, up_word);
		end
	end

	assign dn_valid = valid_q;
	assign dn_word = word_q;

endmodule

@@ hdl/josephson_phase_current_update.sv @@
// ----------------------------------------------------------------------------
// josephson_phase_current_update
// An accepted input word is registered in each of the 12 cells in turn, each
// holding one word. Throughput: one word per cycle while out_stall is low.
// The input stalls only when all 12 slots hold a word and the output is held.
// Bubbles in the row are filled while the output is held.
// Reset clears all slot valid bits and loads gains 0, inverse areas 1.0.
// ----------------------------------------------------------------------------
module josephson_phase_current_update (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [jpcu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jpcu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      direction,
	input  logic [31:0]                     crit_current,
	input  logic signed [31:0]              field,
	input  logic [31:0]                     phase_old,
	input  logic signed [31:0]              super_old,
	input  logic signed [31:0]              current_old,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [31:0]                     phase_new,
	output logic signed [31:0]              super_new,
	output logic signed [31:0]              current_new,
	output logic                            active
);

	localparam int N = jpcu_pkg::NUM_CELLS;

	jpcu_pkg::cfg_t  cfg;
	jpcu_pkg::word_t in_word;
	logic            vld [N+1];
	logic            rdy [N+1];
	jpcu_pkg::word_t wrd [N+1];

	jpcu_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input word into the head of the row
	always_comb begin
		in_word = '0;
		in_word.dir = direction;
		in_word.ic = crit_current;
		in_word.fld = field;
		in_word.ph = phase_old;
		in_word.js_old = super_old;
		in_word.cur_old = current_old;
	end
	assign wrd[0] = in_word;
	assign vld[0] = in_valid;
	assign in_stall = !rdy[0];

	// row of cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		jpcu_cell #(
			.STAGE (4'(i))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg),
			.up_valid (vld[i]),
			.up_ready (rdy[i]),
			.up_word  (wrd[i]),
			.dn_valid (vld[i+1]),
			.dn_ready (rdy[i+1]),
			.dn_word  (wrd[i+1])
		);
	end

	// tail of the row drives the output channel
	assign rdy[N] = !out_stall;
	assign out_valid = vld[N];
	assign phase_new = wrd[N].ph;
	assign super_new = wrd[N].js_new;
	assign current_new = wrd[N].cur_new;
	assign active = wrd[N].act;

endmodule

@@ hdl/jpcu_checker.sv @@
// ----------------------------------------------------------------------------
// jpcu_checker
// Port-level checks on the junction update block, bound to the top level.
// ----------------------------------------------------------------------------
module jpcu_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [31:0]                     phase_new,
	input logic signed [31:0]              super_new,
	input logic signed [31:0]              current_new,
	input logic                            active
);

	// reset empties the row
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output word valid during reset");

	// input only stalls when the whole row is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the row has room");

	// a negative supercurrent only comes from the lower half turn
	a_sine_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && active && super_new[31]) |-> phase_new[31])
		else $error("supercurrent sign disagrees with phase");

	// a held output word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(phase_new)
		&& $stable(super_new) && $stable(current_new) && $stable(active)))
		else $error("stalled output word changed");

endmodule

bind josephson_phase_current_update jpcu_checker u_jpcu_checker (.*);

@@ tb/josephson_phase_current_update_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// josephson_phase_current_update_tb
// Drives junction edge words through the phase and supercurrent update row and
// compares every result word with a bit-exact software model or a typed expectation.
// A directed table covers reset values, pass-through, the wrap and sine corners,
// and saturation. Random words follow under several register settings, with
// random idling on both sides, one long output hold-off and one calm stretch.
// ----------------------------------------------------------------------------
module josephson_phase_current_update_tb;

	localparam int PIPE_LATENCY = 12;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_COUNT = 6;
	localparam int WORDS_PER_PHASE = 217;
	localparam int MAX_PRINTS = 40;
	localparam int IDX_W = jpcu_pkg::CFG_IDX_W;

	// indexes past the register file, writes there must be ignored
	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam logic signed [33:0] CUR_MAX = 34'sd2147483647;
	localparam logic signed [33:0] CUR_MIN = -34'sd2147483648;

	typedef struct {
		logic [1:0]         dir;
		logic [31:0]        ic;
		logic signed [31:0] fld;
		logic [31:0]        ph;
		logic signed [31:0] js;
		logic signed [31:0] cur;
	} edge_in_t;

	typedef struct {
		logic [31:0]        ph;
		logic signed [31:0] js;
		logic signed [31:0] cur;
		logic               act;
	} edge_out_t;

	typedef struct {
		bit               is_write;
		logic [IDX_W-1:0] reg_idx;
		logic [31:0]      reg_val;
		edge_in_t         stim;
		bit               typed;
		edge_out_t        want;
	} plan_row_t;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [IDX_W-1:0]                cfg_index = '0;
	logic [jpcu_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [1:0]                      direction = jpcu_pkg::DIR_X;
	logic [31:0]                     crit_current = '0;
	logic signed [31:0]              field = '0;
	logic [31:0]                     phase_old = '0;
	logic signed [31:0]              super_old = '0;
	logic signed [31:0]              current_old = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [31:0]                     phase_new;
	logic signed [31:0]              super_new;
	logic signed [31:0]              current_new;
	logic                            active;

	// local copy of the register file
	logic [31:0] gain_reg [3] = '{jpcu_pkg::GAIN_RESET, jpcu_pkg::GAIN_RESET,
		jpcu_pkg::GAIN_RESET};
	logic [31:0] area_reg [3] = '{jpcu_pkg::AREA_RESET, jpcu_pkg::AREA_RESET,
		jpcu_pkg::AREA_RESET};

	edge_out_t expected_edges [$];
	plan_row_t directed_plan [$];

	int mismatch_count = 0;
	int edges_sent = 0;
	int results_checked = 0;
	int writes_done = 0;
	int passthrough_seen = 0;
	int negative_seen = 0;
	int saturated_seen = 0;

	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	josephson_phase_current_update u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.direction    (direction),
		.crit_current (crit_current),
		.field        (field),
		.phase_old    (phase_old),
		.super_old    (super_old),
		.current_old  (current_old),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.phase_new    (phase_new),
		.super_new    (super_new),
		.current_new  (current_new),
		.active       (active)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// phase advance, folded polynomial sine, supercurrent and current correction
	function automatic edge_out_t junction_update(input edge_in_t e);
		edge_out_t r;
		logic signed [63:0] prod;
		logic [31:0] h;
		logic [31:0] t;
		logic [63:0] u;
		logic [63:0] t2;
		logic [63:0] inner;
		logic [63:0] mid;
		logic [63:0] y;
		logic [63:0] s;
		logic [65:0] m1;
		logic [65:0] m2;
		logic signed [33:0] sum;
		r.ph = e.ph;
		r.js = e.js;
		r.cur = e.cur;
		r.act = 1'b0;
		if (e.ic == 32'd0 || e.dir == jpcu_pkg::DIR_NONE) begin
			return r;
		end
		prod = $signed(e.fld) * $signed(gain_reg[e.dir]);
		r.ph = e.ph + prod[63:32];
		// quarter-turn fold, angle in Q16 with 1.0 at a quarter turn
		h = {1'b0, r.ph[30:0]};
		t = (h < 32'h4000_0000) ? h : (32'h8000_0000 - h);
		u = (64'(t) + 64'h2000) >> 14;
		t2 = (u * u) >> 16;
		inner = (64'd4640 * t2) >> 16;
		mid = (t2 * (64'd42048 - inner)) >> 16;
		y = (u * (64'd102944 - mid)) >> 16;
		s = (y + 64'd1) >> 1;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		m1 = (66'(e.ic) * 66'(s) + 66'h4000) >> 15;
		m2 = (m1 * 66'(area_reg[e.dir]) + 66'h8000) >> 16;
		// negative side saturates one count further
		if (r.ph[31]) begin
			if (m2 > 66'h8000_0000) begin
				m2 = 66'h8000_0000;
			end
			r.js = 32'd0 - m2[31:0];
		end else begin
			if (m2 > 66'h7FFF_FFFF) begin
				m2 = 66'h7FFF_FFFF;
			end
			r.js = m2[31:0];
		end
		sum = {{2{e.cur[31]}}, e.cur} + {{2{r.js[31]}}, r.js} - {{2{e.js[31]}}, e.js};
		if (sum > CUR_MAX) begin
			r.cur = 32'h7FFF_FFFF;
		end else if (sum < CUR_MIN) begin
			r.cur = 32'h8000_0000;
		end else begin
			r.cur = sum[31:0];
		end
		r.act = 1'b1;
		return r;
	endfunction

	function automatic edge_in_t make_edge(input logic [1:0] dir, input logic [31:0] ic,
			input logic [31:0] fld, input logic [31:0] ph, input logic [31:0] js,
			input logic [31:0] cur);
		edge_in_t e;
		e.dir = dir;
		e.ic = ic;
		e.fld = fld;
		e.ph = ph;
		e.js = js;
		e.cur = cur;
		return e;
	endfunction

	function automatic void add_edge(input logic [1:0] dir, input logic [31:0] ic,
			input logic [31:0] fld, input logic [31:0] ph, input logic [31:0] js,
			input logic [31:0] cur);
		plan_row_t row;
		row.is_write = 1'b0;
		row.typed = 1'b0;
		row.stim = make_edge(dir, ic, fld, ph, js, cur);
		directed_plan.push_back(row);
	endfunction

	function automatic void add_typed(input logic [1:0] dir, input logic [31:0] ic,
			input logic [31:0] fld, input logic [31:0] ph, input logic [31:0] js,
			input logic [31:0] cur, input logic [31:0] w_ph, input logic [31:0] w_js,
			input logic [31:0] w_cur, input logic w_act);
		plan_row_t row;
		row.is_write = 1'b0;
		row.typed = 1'b1;
		row.stim = make_edge(dir, ic, fld, ph, js, cur);
		row.want.ph = w_ph;
		row.want.js = w_js;
		row.want.cur = w_cur;
		row.want.act = w_act;
		directed_plan.push_back(row);
	endfunction

	function automatic void add_write(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		plan_row_t row;
		row.is_write = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		row.typed = 1'b0;
		directed_plan.push_back(row);
	endfunction

	// operand mix: rails, zero, small signed values and full random
	function automatic logic [31:0] wide_value();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 10) return 32'h7FFF_FFFF;
		if (roll < 20) return 32'h8000_0000;
		if (roll < 25) return 32'd0;
		if (roll < 30) return 32'hFFFF_FFFF;
		if (roll < 50) return 32'($urandom_range(32'h0001_FFFF)) - 32'h0001_0000;
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_reg(input bit is_area);
		case ($urandom_range(5))
			0: return is_area ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
			1: return is_area ? 32'd0 : 32'h8000_0000;
			2: return is_area ? jpcu_pkg::AREA_RESET : jpcu_pkg::GAIN_RESET;
			3: return is_area ? 32'($urandom_range(32'h0004_0000))
				: 32'($urandom_range(32'h0007_FFFF)) - 32'h0004_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic edge_in_t random_edge();
		edge_in_t e;
		int unsigned roll;
		e.dir = ($urandom_range(99) < 6) ? jpcu_pkg::DIR_NONE : 2'($urandom_range(2));
		roll = $urandom_range(99);
		if (roll < 8) begin
			e.ic = 32'd0;
		end else if (roll < 13) begin
			e.ic = 32'hFFFF_FFFF;
		end else if (roll < 55) begin
			e.ic = $urandom_range(32'h0010_0000, 1);
		end else begin
			e.ic = $urandom;
		end
		e.fld = wide_value();
		e.js = wide_value();
		e.cur = wide_value();
		// some phases sit right at a quadrant boundary
		if ($urandom_range(99) < 20) begin
			e.ph = {2'($urandom_range(3)), 30'd0} + 32'($urandom_range(16)) - 32'd8;
		end else begin
			e.ph = $urandom;
		end
		return e;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < MAX_PRINTS) begin
			$display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
		end
		mismatch_count++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < jpcu_pkg::NUM_REGS) begin
			if (idx < jpcu_pkg::REG_AREA_X) begin
				gain_reg[idx] = val;
			end else begin
				area_reg[idx - jpcu_pkg::REG_AREA_X] = val;
			end
		end
		writes_done++;
		@(posedge clk);
	endtask

	// stop offering, let every pending word come out, then let the row empty
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_edges.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_edge(input edge_in_t e, input bit typed, input edge_out_t want);
		if (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		direction <= e.dir;
		crit_current <= e.ic;
		field <= e.fld;
		phase_old <= e.ph;
		super_old <= e.js;
		current_old <= e.cur;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		expected_edges.push_back(typed ? want : junction_update(e));
		edges_sent++;
	endtask

	// output side: random stalls, one long hold-off, none while calm
	always begin : drive_out_stall
		@(posedge clk);
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			out_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			out_stall <= 1'b0;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 22);
		end
	end

	// result check against the oldest pending expectation
	always @(posedge clk) begin : check_results
		edge_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_edges.size() == 0) begin
				report_mismatch("result word with nothing pending", phase_new, 32'd0);
			end else begin
				want = expected_edges.pop_front();
				if (phase_new !== want.ph) begin
					report_mismatch("phase_new", phase_new, want.ph);
				end
				if (super_new !== want.js) begin
					report_mismatch("super_new", super_new, want.js);
				end
				if (current_new !== want.cur) begin
					report_mismatch("current_new", current_new, want.cur);
				end
				if (active !== want.act) begin
					report_mismatch("active", 32'(active), 32'(want.act));
				end
				results_checked++;
				if (!want.act) begin
					passthrough_seen++;
				end else begin
					if (want.js[31]) negative_seen++;
					if (want.js == 32'h7FFF_FFFF || want.js == 32'h8000_0000) saturated_seen++;
				end
			end
		end
	end

	initial begin : stimulus
		edge_out_t blank;
		int phase_no;
		int k;
		int r;
		blank = '{default: '0};

		// reset values, pass-through and sine corners under reset registers
		add_typed(jpcu_pkg::DIR_X, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0000,
			32'h0000_0000, 32'h0000_0100,
			32'h0000_0000, 32'h0000_0000, 32'h0000_0100, 1'b1);
		add_typed(jpcu_pkg::DIR_Z, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		add_typed(jpcu_pkg::DIR_NONE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678,
			32'h7FFF_FFFF, 32'h8000_0000,
			32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		// half turn: zero sine on the negative side, no sign on the result
		add_typed(jpcu_pkg::DIR_Y, 32'h0001_0000, 32'h0003_0000, 32'h8000_0000,
			32'h0000_0005, 32'h0000_000A,
			32'h8000_0000, 32'h0000_0000, 32'h0000_0005, 1'b1);
		add_edge(jpcu_pkg::DIR_X, 32'h0001_0000, 32'h0000_0000, 32'h4000_0000,
			32'h0000_0000, 32'h0);
		add_edge(jpcu_pkg::DIR_Z, 32'h0001_0000, 32'h0000_0000, 32'hC000_0000,
			32'h0000_0000, 32'h0);
		add_edge(jpcu_pkg::DIR_Y, 32'hFFFF_FFFF, 32'h0000_0000, 32'h3FFF_FFFF,
			32'h0000_0000, 32'h0);
		// register extremes, plus writes past the register file
		add_write(jpcu_pkg::REG_GAIN_X, 32'h7FFF_FFFF);
		add_write(jpcu_pkg::REG_GAIN_Y, 32'h8000_0000);
		add_write(jpcu_pkg::REG_GAIN_Z, 32'h0001_0000);
		add_write(jpcu_pkg::REG_AREA_X, 32'hFFFF_FFFF);
		add_write(jpcu_pkg::REG_AREA_Y, 32'h0000_0000);
		add_write(jpcu_pkg::REG_AREA_Z, 32'h0002_0000);
		add_write(REG_SPARE_A, 32'h5A5A_5A5A);
		add_write(REG_SPARE_B, 32'hA5A5_A5A5);
		// saturation of supercurrent and current on both rails
		add_edge(jpcu_pkg::DIR_X, 32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000,
			32'h0000_0000, 32'h0);
		add_edge(jpcu_pkg::DIR_X, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hC000_0000,
			32'h7FFF_FFFF, 32'h8000_0000);
		add_edge(jpcu_pkg::DIR_Y, 32'h0005_0000, 32'h7FFF_FFFF, 32'h9ABC_DEF0,
			32'h0000_1234, 32'h0);
		add_edge(jpcu_pkg::DIR_Z, 32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000,
			32'h8000_0000, 32'h7FFF_FFFF);
		add_edge(jpcu_pkg::DIR_Z, 32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_edge(jpcu_pkg::DIR_X, 32'h0000_0001, 32'h8000_0000, 32'h0000_0000,
			32'h0000_0000, 32'h0);
		add_edge(jpcu_pkg::DIR_Y, 32'hAAAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA,
			32'hAAAA_AAAA, 32'h5555_5555);
		add_typed(jpcu_pkg::DIR_NONE, 32'h0000_0000, 32'h0F0F_0F0F, 32'h0F0F_0F0F,
			32'hF0F0_F0F0, 32'h00FF_00FF,
			32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h00FF_00FF, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_write) begin
				drain_pipeline();
				write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
			end else begin
				send_edge(directed_plan[i].stim, directed_plan[i].typed, directed_plan[i].want);
			end
		end

		// random words under a new register setting per phase
		for (phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
			drain_pipeline();
			write_reg(($urandom_range(1)) ? REG_SPARE_A : REG_SPARE_B, $urandom);
			for (r = 0; r < jpcu_pkg::NUM_REGS; r++) begin
				case (phase_no)
					0: write_reg(IDX_W'(r),
						(r < jpcu_pkg::REG_AREA_X) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF);
					1: write_reg(IDX_W'(r),
						(r < jpcu_pkg::REG_AREA_X) ? 32'h8000_0000 : 32'h0000_0000);
					default: write_reg(IDX_W'(r), pick_reg(r >= jpcu_pkg::REG_AREA_X));
				endcase
			end
			calm = (phase_no == 2);
			for (k = 0; k < WORDS_PER_PHASE; k++) begin
				if (phase_no == 3 && k == 40) begin
					hold_req = 1'b1;
				end
				send_edge(random_edge(), 1'b0, blank);
			end
			calm = 1'b0;
		end

		drain_pipeline();
		$display("checked %0d of %0d edge words across %0d register writes and %0d settings",
			results_checked, edges_sent, writes_done, PHASE_COUNT + 1);
		$display("%0d passed through, %0d negative sine, %0d saturated supercurrents",
			passthrough_seen, negative_seen, saturated_seen);
		if (mismatch_count == 0 && expected_edges.size() == 0) begin
			$display("josephson_phase_current_update_tb OK");
		end else begin
			$display("josephson_phase_current_update_tb NOT OK");
		end
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin : watchdog
		#2_000_000;
		$display("timeout with %0d result words still pending", expected_edges.size());
		$display("josephson_phase_current_update_tb NOT OK");
		$finish;
	end

endmodule
